// ===== hw/rtl/qbnt_pkg.sv =====
// Shared types, constants and the microcode table for the body-to-NED transform.
// The quaternion products and matrix rows are sequenced as serial multiply steps.
// No dependencies.
package qbnt_pkg;

	localparam int CordicSteps = 16;
	localparam int CordicIdxW  = (CordicSteps > 1) ? $clog2(CordicSteps) : 1;
	localparam int AtanIdxW    = 5;

	localparam int MacAW = 26;   // multiplicand: matrix element, quaternion or constant
	localparam int MacBW = 32;   // multiplier: shifted out one bit per cycle
	localparam int AccW  = 64;
	localparam int CntW  = 6;
	localparam int PcW   = 5;

	localparam int VecW     = 34;  // atan2 operands, Q.28 doubled
	localparam int CordicXW = 37;  // operand plus CORDIC gain plus rotation headroom
	localparam int AngW     = 33;  // Q.29 radians
	localparam int HeadW    = 35;

	localparam logic signed [AngW-1:0]  HalfPiQ29  = 33'sd843314857;
	localparam logic signed [HeadW-1:0] PiQ29      = 35'sd1686629713;
	localparam logic signed [HeadW-1:0] TwoPiQ29   = 35'sd3373259426;
	localparam logic signed [MacBW-1:0] Deg2RadQ29 = 32'sd9370165;
	localparam logic signed [AccW-1:0]  OneQ28     = 64'sd268435456;

	localparam logic [PcW-1:0] ProgAttitude = 5'd0;
	localparam logic [PcW-1:0] ProgXform    = 5'd4;

	typedef enum logic [4:0] {
		OPD_HW, OPD_HX, OPD_HY, OPD_HZ,
		OPD_IW, OPD_IX, OPD_IY, OPD_IZ,
		OPD_M00, OPD_M01, OPD_M02, OPD_M10, OPD_M11, OPD_M12,
		OPD_BX, OPD_BY, OPD_BZ, OPD_HDG, OPD_D2R
	} opd_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_NORM, DST_R00, DST_R01, DST_R02, DST_R10, DST_R11, DST_R12,
		DST_XC, DST_NORTH, DST_EAST, DST_THETA
	} dst_t;

	typedef struct packed {
		opd_t a_sel;
		opd_t b_sel;
		logic neg;
		logic first;
		dst_t dst;
		logic last;
	} ustep_t;

	typedef struct packed {
		logic            start;
		logic            clear;
		logic            neg;
		logic [CntW-1:0] nbits;
	} mac_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	function automatic ustep_t ucode(input logic [PcW-1:0] pc);
		ustep_t s;
		case (pc)
			// attitude: squared norm of the offered quaternion
			5'd0:  s = '{OPD_IW, OPD_IW, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd1:  s = '{OPD_IX, OPD_IX, 1'b0, 1'b0, DST_NONE, 1'b0};
			5'd2:  s = '{OPD_IY, OPD_IY, 1'b0, 1'b0, DST_NONE, 1'b0};
			5'd3:  s = '{OPD_IZ, OPD_IZ, 1'b0, 1'b0, DST_NORM, 1'b1};
			// transform: rotation matrix rows
			5'd4:  s = '{OPD_HW, OPD_HW, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd5:  s = '{OPD_HX, OPD_HX, 1'b0, 1'b0, DST_NONE, 1'b0};
			5'd6:  s = '{OPD_HY, OPD_HY, 1'b1, 1'b0, DST_NONE, 1'b0};
			5'd7:  s = '{OPD_HZ, OPD_HZ, 1'b1, 1'b0, DST_R00, 1'b0};
			5'd8:  s = '{OPD_HX, OPD_HY, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd9:  s = '{OPD_HW, OPD_HZ, 1'b1, 1'b0, DST_R01, 1'b0};
			5'd10: s = '{OPD_HX, OPD_HZ, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd11: s = '{OPD_HW, OPD_HY, 1'b0, 1'b0, DST_R02, 1'b0};
			5'd12: s = '{OPD_HX, OPD_HY, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd13: s = '{OPD_HW, OPD_HZ, 1'b0, 1'b0, DST_R10, 1'b0};
			5'd14: s = '{OPD_HW, OPD_HW, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd15: s = '{OPD_HX, OPD_HX, 1'b1, 1'b0, DST_NONE, 1'b0};
			5'd16: s = '{OPD_HY, OPD_HY, 1'b0, 1'b0, DST_NONE, 1'b0};
			5'd17: s = '{OPD_HZ, OPD_HZ, 1'b1, 1'b0, DST_R11, 1'b0};
			5'd18: s = '{OPD_HY, OPD_HZ, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd19: s = '{OPD_HW, OPD_HX, 1'b1, 1'b0, DST_R12, 1'b0};
			// atan2 x operand
			5'd20: s = '{OPD_HW, OPD_HW, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd21: s = '{OPD_HX, OPD_HX, 1'b0, 1'b0, DST_XC, 1'b0};
			// matrix times body offset
			5'd22: s = '{OPD_M00, OPD_BX, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd23: s = '{OPD_M01, OPD_BY, 1'b0, 1'b0, DST_NONE, 1'b0};
			5'd24: s = '{OPD_M02, OPD_BZ, 1'b0, 1'b0, DST_NORTH, 1'b0};
			5'd25: s = '{OPD_M10, OPD_BX, 1'b0, 1'b1, DST_NONE, 1'b0};
			5'd26: s = '{OPD_M11, OPD_BY, 1'b0, 1'b0, DST_NONE, 1'b0};
			5'd27: s = '{OPD_M12, OPD_BZ, 1'b0, 1'b0, DST_EAST, 1'b0};
			5'd28: s = '{OPD_D2R, OPD_HDG, 1'b0, 1'b1, DST_THETA, 1'b1};
			default: s = '{OPD_D2R, OPD_HDG, 1'b0, 1'b1, DST_NONE, 1'b1};
		endcase
		return s;
	endfunction

	function automatic logic [CntW-1:0] opd_bits(input opd_t sel);
		logic [CntW-1:0] n;
		case (sel)
			OPD_BX, OPD_BY, OPD_BZ: n = 6'd32;
			OPD_HDG:                n = 6'd15;
			default:                n = 6'd16;
		endcase
		return n;
	endfunction

	// arctan(2^-i) in Q.29, rounded
	function automatic logic [29:0] atan_tab(input logic [AtanIdxW-1:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd421657428;
			5'd1:  v = 30'd248918915;
			5'd2:  v = 30'd131521918;
			5'd3:  v = 30'd66762579;
			5'd4:  v = 30'd33510843;
			5'd5:  v = 30'd16771758;
			5'd6:  v = 30'd8387925;
			5'd7:  v = 30'd4194219;
			5'd8:  v = 30'd2097141;
			5'd9:  v = 30'd1048575;
			5'd10: v = 30'd524288;
			5'd11: v = 30'd262144;
			5'd12: v = 30'd131072;
			5'd13: v = 30'd65536;
			5'd14: v = 30'd32768;
			5'd15: v = 30'd16384;
			5'd16: v = 30'd8192;
			5'd17: v = 30'd4096;
			5'd18: v = 30'd2048;
			5'd19: v = 30'd1024;
			5'd20: v = 30'd512;
			5'd21: v = 30'd256;
			5'd22: v = 30'd128;
			5'd23: v = 30'd64;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/quaternion_body_to_ned_transform_core.sv =====
// Top level of the body-to-NED target transform: sequencer, operand and result registers.
// Depends on qbnt_pkg, qbnt_serial_mac and qbnt_cordic.
//
// Usage:
//   s_axis carries one event per transaction; tuser selects the kind (0 attitude
//   quaternion, 1 target transform). m_axis returns exactly one result per event,
//   in order, with tuser echoing the kind.
//   cfg_we/cfg_wdata write the norm tolerance (Q1.14); write it only while idle.
// Sequencing:
//   All products run on one bit-serial multiplier, one multiply step after
//   another, each step passing through ST_LOAD, ST_MUL and ST_STORE.
//   An attitude result follows the norm steps; a transform result follows 25
//   multiply steps, then the iterative atan2, then the heading wrap.
//   One event is processed at a time; s_axis_tready is high only when idle.
// Reset:
//   Held quaternion clears to zero, tolerance returns to 3277, no result pending.
// Stalls:
//   A finished result sits in the output register; the input side accepts the
//   next event meanwhile, and that event's result waits until the register frees.
module quaternion_body_to_ned_transform_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [14:0]  cfg_wdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// quat_w, quat_x, quat_y, quat_z, body_x, body_y, body_z, heading_deg,
	// vehicle_north, vehicle_east; zero pad to 240
	input  logic [239:0] s_axis_tdata,
	input  logic [0:0]   s_axis_tuser,  // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// quat_accepted, target_north, target_east, target_heading; zero pad to 88
	output logic [87:0]  m_axis_tdata,
	output logic [0:0]   m_axis_tuser   // kind
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_MUL, ST_STORE, ST_CORDIC, ST_CWAIT, ST_HEAD, ST_OUT
	} state_t;

	state_t                 state_q;
	logic [qbnt_pkg::PcW-1:0] pc_q;
	logic [14:0]            tol_q;
	logic signed [15:0]     held_q [4];
	logic                   op_q;
	logic signed [15:0]     qin_q [4];
	logic signed [31:0]     body_q [3];
	logic signed [14:0]     hdg_q;
	logic signed [31:0]     pn_q;
	logic signed [31:0]     pe_q;
	logic signed [qbnt_pkg::MacAW-1:0] m_q [6];
	logic signed [qbnt_pkg::VecW-1:0]  yc_q;
	logic signed [qbnt_pkg::VecW-1:0]  xc_q;
	logic signed [31:0]     north_q;
	logic signed [31:0]     east_q;
	logic signed [qbnt_pkg::AngW-1:0] theta_q;
	logic signed [qbnt_pkg::AngW-1:0] yaw_q;
	logic signed [15:0]     head_q;
	logic                   norm_ok_q;
	logic                   out_valid_q;
	logic [87:0]            out_data_q;
	logic                   out_kind_q;

	qbnt_pkg::ustep_t       step;
	qbnt_pkg::mac_cmd_t     mac_cmd;
	qbnt_pkg::unit_sts_t    mac_sts;
	qbnt_pkg::unit_sts_t    cor_sts;
	logic signed [qbnt_pkg::AccW-1:0]  acc;
	logic signed [qbnt_pkg::AngW-1:0]  cor_angle;
	logic signed [31:0]     a_full;
	logic signed [31:0]     b_full;
	logic signed [qbnt_pkg::AccW-1:0]  dbl;
	logic signed [qbnt_pkg::AccW-1:0]  elem_src;
	logic signed [qbnt_pkg::AccW-1:0]  elem_v;
	logic signed [qbnt_pkg::AccW-1:0]  xc_v;
	logic signed [qbnt_pkg::AccW-1:0]  row_v;
	logic signed [31:0]     row_sat;
	logic signed [qbnt_pkg::AccW-1:0]  theta_v;
	logic signed [qbnt_pkg::AccW-1:0]  nd;
	logic signed [qbnt_pkg::AccW-1:0]  nd_abs;
	logic                   norm_ok;
	logic signed [qbnt_pkg::HeadW-1:0] g0;
	logic signed [qbnt_pkg::HeadW-1:0] g1;
	logic signed [qbnt_pkg::HeadW-1:0] g2;
	logic signed [qbnt_pkg::HeadW-1:0] hr;
	logic                   in_acc;

	assign step   = qbnt_pkg::ucode(pc_q);
	assign in_acc = s_axis_tvalid && s_axis_tready;

	function automatic logic signed [31:0] opd_val(
		input qbnt_pkg::opd_t sel,
		input logic signed [15:0] hw, input logic signed [15:0] hx,
		input logic signed [15:0] hy, input logic signed [15:0] hz,
		input logic signed [15:0] iw, input logic signed [15:0] ix,
		input logic signed [15:0] iy, input logic signed [15:0] iz,
		input logic signed [qbnt_pkg::MacAW-1:0] m00,
		input logic signed [qbnt_pkg::MacAW-1:0] m01,
		input logic signed [qbnt_pkg::MacAW-1:0] m02,
		input logic signed [qbnt_pkg::MacAW-1:0] m10,
		input logic signed [qbnt_pkg::MacAW-1:0] m11,
		input logic signed [qbnt_pkg::MacAW-1:0] m12,
		input logic signed [31:0] bx, input logic signed [31:0] by,
		input logic signed [31:0] bz, input logic signed [14:0] hd);
		logic signed [31:0] v;
		case (sel)
			qbnt_pkg::OPD_HW:  v = 32'(hw);
			qbnt_pkg::OPD_HX:  v = 32'(hx);
			qbnt_pkg::OPD_HY:  v = 32'(hy);
			qbnt_pkg::OPD_HZ:  v = 32'(hz);
			qbnt_pkg::OPD_IW:  v = 32'(iw);
			qbnt_pkg::OPD_IX:  v = 32'(ix);
			qbnt_pkg::OPD_IY:  v = 32'(iy);
			qbnt_pkg::OPD_IZ:  v = 32'(iz);
			qbnt_pkg::OPD_M00: v = 32'(m00);
			qbnt_pkg::OPD_M01: v = 32'(m01);
			qbnt_pkg::OPD_M02: v = 32'(m02);
			qbnt_pkg::OPD_M10: v = 32'(m10);
			qbnt_pkg::OPD_M11: v = 32'(m11);
			qbnt_pkg::OPD_M12: v = 32'(m12);
			qbnt_pkg::OPD_BX:  v = bx;
			qbnt_pkg::OPD_BY:  v = by;
			qbnt_pkg::OPD_BZ:  v = bz;
			qbnt_pkg::OPD_HDG: v = 32'(hd);
			qbnt_pkg::OPD_D2R: v = qbnt_pkg::Deg2RadQ29;
			default:           v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		a_full = opd_val(step.a_sel, held_q[0], held_q[1], held_q[2], held_q[3],
			qin_q[0], qin_q[1], qin_q[2], qin_q[3],
			m_q[0], m_q[1], m_q[2], m_q[3], m_q[4], m_q[5],
			body_q[0], body_q[1], body_q[2], hdg_q);
		b_full = opd_val(step.b_sel, held_q[0], held_q[1], held_q[2], held_q[3],
			qin_q[0], qin_q[1], qin_q[2], qin_q[3],
			m_q[0], m_q[1], m_q[2], m_q[3], m_q[4], m_q[5],
			body_q[0], body_q[1], body_q[2], hdg_q);
		mac_cmd.start = (state_q == ST_LOAD);
		mac_cmd.clear = step.first;
		mac_cmd.neg   = step.neg;
		mac_cmd.nbits = qbnt_pkg::opd_bits(step.b_sel);
	end

	qbnt_serial_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.a      (a_full[qbnt_pkg::MacAW-1:0]),
		.b      (b_full),
		.sts    (mac_sts),
		.acc    (acc)
	);

	qbnt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_CORDIC),
		.y_in   (yc_q),
		.x_in   (xc_q),
		.sts    (cor_sts),
		.angle  (cor_angle)
	);

	// result shaping for the step that just finished
	always_comb begin
		dbl      = acc <<< 1;
		elem_src = ((step.dst == qbnt_pkg::DST_R00) || (step.dst == qbnt_pkg::DST_R11))
			? acc : dbl;
		elem_v   = (elem_src + 64'sd128) >>> 8;
		xc_v     = dbl - qbnt_pkg::OneQ28;
		row_v    = ((acc + 64'sd524288) >>> 20)
			+ qbnt_pkg::AccW'((step.dst == qbnt_pkg::DST_NORTH) ? pn_q : pe_q);
		if (row_v > 64'sd2147483647) begin
			row_sat = 32'sh7FFFFFFF;
		end else if (row_v < -64'sd2147483648) begin
			row_sat = 32'sh80000000;
		end else begin
			row_sat = row_v[31:0];
		end
		theta_v  = (acc + 64'sd32) >>> 6;
		nd       = acc - qbnt_pkg::OneQ28;
		nd_abs   = (nd < 0) ? -nd : nd;
		norm_ok  = nd_abs <= (qbnt_pkg::AccW'(tol_q) << 14);
		// heading wraps a single time
		g0 = qbnt_pkg::HeadW'(yaw_q) + qbnt_pkg::HeadW'(theta_q);
		g1 = (g0 < -qbnt_pkg::PiQ29) ? (g0 + qbnt_pkg::TwoPiQ29) : g0;
		g2 = (g1 > qbnt_pkg::PiQ29) ? (g1 - qbnt_pkg::TwoPiQ29) : g1;
		hr = (g2 + 35'sd32768) >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pc_q        <= '0;
			tol_q       <= 15'd3277;
			held_q      <= '{default: '0};
			norm_ok_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_kind_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			// in ST_OUT the output register is reloaded below instead
			if (out_valid_q && m_axis_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						norm_ok_q <= 1'b0;
						pc_q      <= s_axis_tuser[0] ? qbnt_pkg::ProgXform
							: qbnt_pkg::ProgAttitude;
						state_q   <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (mac_sts.done) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if ((step.dst == qbnt_pkg::DST_NORM) && norm_ok) begin
						norm_ok_q <= 1'b1;
						held_q    <= qin_q;
					end
					if (step.last) begin
						state_q <= op_q ? ST_CORDIC : ST_OUT;
					end else begin
						pc_q    <= pc_q + qbnt_pkg::PcW'(1);
						state_q <= ST_LOAD;
					end
				end
				ST_CORDIC: begin
					state_q <= ST_CWAIT;
				end
				ST_CWAIT: begin
					if (cor_sts.done) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_kind_q  <= op_q;
						if (op_q) begin
							out_data_q <= {7'd0, head_q, east_q, north_q, 1'b0};
						end else begin
							out_data_q <= {87'd0, norm_ok_q};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q      <= s_axis_tuser[0];
			qin_q[0]  <= s_axis_tdata[15:0];
			qin_q[1]  <= s_axis_tdata[31:16];
			qin_q[2]  <= s_axis_tdata[47:32];
			qin_q[3]  <= s_axis_tdata[63:48];
			body_q[0] <= s_axis_tdata[95:64];
			body_q[1] <= s_axis_tdata[127:96];
			body_q[2] <= s_axis_tdata[159:128];
			hdg_q     <= s_axis_tdata[174:160];
			pn_q      <= s_axis_tdata[206:175];
			pe_q      <= s_axis_tdata[238:207];
		end
		if (state_q == ST_STORE) begin
			case (step.dst)
				qbnt_pkg::DST_R00: m_q[0] <= elem_v[qbnt_pkg::MacAW-1:0];
				qbnt_pkg::DST_R01: m_q[1] <= elem_v[qbnt_pkg::MacAW-1:0];
				qbnt_pkg::DST_R02: m_q[2] <= elem_v[qbnt_pkg::MacAW-1:0];
				qbnt_pkg::DST_R10: begin
					m_q[3] <= elem_v[qbnt_pkg::MacAW-1:0];
					yc_q   <= dbl[qbnt_pkg::VecW-1:0];
				end
				qbnt_pkg::DST_R11:   m_q[4]  <= elem_v[qbnt_pkg::MacAW-1:0];
				qbnt_pkg::DST_R12:   m_q[5]  <= elem_v[qbnt_pkg::MacAW-1:0];
				qbnt_pkg::DST_XC:    xc_q    <= xc_v[qbnt_pkg::VecW-1:0];
				qbnt_pkg::DST_NORTH: north_q <= row_sat;
				qbnt_pkg::DST_EAST:  east_q  <= row_sat;
				qbnt_pkg::DST_THETA: theta_q <= theta_v[qbnt_pkg::AngW-1:0];
				default: ;
			endcase
		end
		if ((state_q == ST_CWAIT) && cor_sts.done) begin
			yaw_q <= cor_angle;
		end
		if (state_q == ST_HEAD) begin
			head_q <= hr[15:0];
		end
	end

	assign s_axis_tready   = (state_q == ST_IDLE);
	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = out_data_q;
	assign m_axis_tuser[0] = out_kind_q;

`ifndef ASSERT_OFF
	a_mac_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		mac_cmd.start |-> !mac_sts.busy)
		else $error("multiply step issued while multiplier busy");
	a_cordic_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		cor_sts.done |-> (state_q == ST_CWAIT))
		else $error("atan2 finished outside its wait state");
	a_attitude_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[87:1] == '0))
		else $error("attitude result carries transform data");
	a_xform_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tdata[0])
		else $error("transform result flags a quaternion update");
`endif

endmodule

// ===== hw/rtl/qbnt_serial_mac.sv =====
// Bit-serial signed multiply-accumulate: one multiplier bit per cycle, LSB first.
// Uses qbnt_pkg for widths and the command/status structs.
module qbnt_serial_mac (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qbnt_pkg::mac_cmd_t                   cmd,
	input  logic signed [qbnt_pkg::MacAW-1:0]    a,
	input  logic signed [qbnt_pkg::MacBW-1:0]    b,
	output qbnt_pkg::unit_sts_t                  sts,
	output logic signed [qbnt_pkg::AccW-1:0]     acc
);

	logic signed [qbnt_pkg::AccW-1:0]  a_sh_q;
	logic        [qbnt_pkg::MacBW-1:0] b_sh_q;
	logic        [qbnt_pkg::CntW-1:0]  cnt_q;
	logic                              neg_q;
	logic signed [qbnt_pkg::AccW-1:0]  acc_q;
	logic                              busy_q;
	logic                              done_q;
	logic signed [qbnt_pkg::AccW-1:0]  term;
	logic                              sub;
	logic signed [qbnt_pkg::AccW-1:0]  acc_nxt;

	always_comb begin
		term    = b_sh_q[0] ? a_sh_q : '0;
		// top bit of the multiplier carries negative weight
		sub     = neg_q ^ (cnt_q == qbnt_pkg::CntW'(1));
		acc_nxt = sub ? (acc_q - term) : (acc_q + term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - qbnt_pkg::CntW'(1);
				if (cnt_q == qbnt_pkg::CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_sh_q <= qbnt_pkg::AccW'(a);
			b_sh_q <= b;
			neg_q  <= cmd.neg;
			if (cmd.clear) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q  <= acc_nxt;
			a_sh_q <= a_sh_q <<< 1;
			b_sh_q <= b_sh_q >> 1;
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign acc      = acc_q;

endmodule

// ===== hw/rtl/qbnt_cordic.sv =====
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
// Uses qbnt_pkg for widths, step count and the arctangent table.
module qbnt_cordic (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [qbnt_pkg::VecW-1:0]    y_in,
	input  logic signed [qbnt_pkg::VecW-1:0]    x_in,
	output qbnt_pkg::unit_sts_t                 sts,
	output logic signed [qbnt_pkg::AngW-1:0]    angle
);

	logic signed [qbnt_pkg::CordicXW-1:0] x_q;
	logic signed [qbnt_pkg::CordicXW-1:0] y_q;
	logic signed [qbnt_pkg::AngW-1:0]     z_q;
	logic        [qbnt_pkg::CordicIdxW-1:0] i_q;
	logic                                 busy_q;
	logic                                 done_q;
	logic signed [qbnt_pkg::CordicXW-1:0] xe;
	logic signed [qbnt_pkg::CordicXW-1:0] ye;
	logic signed [qbnt_pkg::CordicXW-1:0] xs;
	logic signed [qbnt_pkg::CordicXW-1:0] ys;
	logic signed [qbnt_pkg::AngW-1:0]     step_ang;
	logic                                 zero_in;

	always_comb begin
		xe       = qbnt_pkg::CordicXW'(x_in);
		ye       = qbnt_pkg::CordicXW'(y_in);
		zero_in  = (x_in == '0) && (y_in == '0);
		xs       = x_q >>> i_q;
		ys       = y_q >>> i_q;
		step_ang = qbnt_pkg::AngW'($signed({1'b0,
			qbnt_pkg::atan_tab(qbnt_pkg::AtanIdxW'(i_q))}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (zero_in) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (i_q == qbnt_pkg::CordicIdxW'(qbnt_pkg::CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + qbnt_pkg::CordicIdxW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// zero input gives a zero angle; left half plane: pre-rotate by a quarter turn
			if (zero_in) begin
				z_q <= '0;
			end else if (x_in < 0) begin
				if (y_in >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= qbnt_pkg::HalfPiQ29;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= -qbnt_pkg::HalfPiQ29;
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q > 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step_ang;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step_ang;
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign angle    = z_q;

endmodule

// ===== test/quaternion_body_to_ned_transform_core_test.sv =====
// Self-checking testbench for quaternion_body_to_ned_transform_core.
// Carries its own fixed-point predictor of the norm check, rotation and CORDIC yaw.
// Depends on qbnt_pkg and the core RTL.
module quaternion_body_to_ned_transform_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StallLimit = 20000;
	localparam logic OP_ATTITUDE = 1'b0;
	localparam logic OP_XFORM    = 1'b1;
	localparam longint PiFix     = 64'sd1686629713;
	localparam longint TwoPiFix  = 64'sd3373259426;
	localparam longint HalfPiFix = 64'sd843314857;
	localparam longint DegToRad  = 64'sd9370165;
	localparam longint OneFix    = 64'sd268435456;

	typedef struct packed {
		logic               op;
		logic signed [15:0] qw, qx, qy, qz;
		logic signed [31:0] bx, by, bz;
		logic signed [14:0] hdg;
		logic signed [31:0] pn, pe;
	} event_t;

	typedef struct packed {
		logic               kind;
		logic               accepted;
		logic signed [31:0] north, east;
		logic signed [15:0] heading;
	} fix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [14:0] cfg_wdata = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [239:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;

	quaternion_body_to_ned_transform_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always #5 clk = ~clk;

	// predictor state
	longint tol_q = 3277;
	longint held_q[4] = '{0, 0, 0, 0};
	fix_t pending_fixes[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_off = 0;
	int quiet_cycles = 0;

	function automatic longint asr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint yaw_atan2(longint y, longint x);
		longint ang, t, xs, ys;
		ang = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; ang = HalfPiFix;
			end else begin
				x = -y; y = t; ang = -HalfPiFix;
			end
		end
		for (int i = 0; i < qbnt_pkg::CordicSteps && i < 24; i++) begin
			xs = asr(x, i);
			ys = asr(y, i);
			if (y > 0) begin
				x += ys; y -= xs; ang += longint'(qbnt_pkg::atan_tab(i[4:0]));
			end else begin
				x -= ys; y += xs; ang -= longint'(qbnt_pkg::atan_tab(i[4:0]));
			end
		end
		return ang;
	endfunction

	function automatic longint row_dot(longint r0, longint r1, longint r2,
			longint bx, longint by, longint bz, longint pos);
		longint s;
		s = asr(r0 + 128, 8) * bx + asr(r1 + 128, 8) * by + asr(r2 + 128, 8) * bz;
		return sat32(asr(s + (64'sd1 <<< 19), 20) + pos);
	endfunction

	function automatic fix_t predict_fix(event_t e);
		fix_t f;
		longint w, x, y, z, ww, xx, yy, zz, n, d, g;
		f = '0;
		f.kind = e.op;
		if (e.op == OP_ATTITUDE) begin
			n = longint'(e.qw) * e.qw + longint'(e.qx) * e.qx
				+ longint'(e.qy) * e.qy + longint'(e.qz) * e.qz;
			d = n - OneFix;
			if (d < 0) d = -d;
			if (d <= (tol_q <<< 14)) begin
				held_q = '{longint'(e.qw), longint'(e.qx), longint'(e.qy), longint'(e.qz)};
				f.accepted = 1'b1;
			end
		end else begin
			w = held_q[0]; x = held_q[1]; y = held_q[2]; z = held_q[3];
			ww = w * w; xx = x * x; yy = y * y; zz = z * z;
			f.north = 32'(row_dot(ww + xx - yy - zz, 2 * (x * y - w * z),
				2 * (x * z + w * y), e.bx, e.by, e.bz, e.pn));
			f.east = 32'(row_dot(2 * (x * y + w * z), ww - xx + yy - zz,
				2 * (y * z - w * x), e.bx, e.by, e.bz, e.pe));
			g = yaw_atan2(2 * (z * w + x * y), 2 * (ww + xx) - OneFix)
				+ asr(longint'(e.hdg) * DegToRad + 32, 6);
			if (g < -PiFix) g += TwoPiFix;
			if (g > PiFix) g -= TwoPiFix;
			f.heading = 16'(asr(g + 32768, 16));
		end
		return f;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	// valid stays up between back-to-back transactions; drain() drops it
	task automatic send_event(event_t e);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= e.op;
		s_axis_tdata <= {1'b0, e.pe, e.pn, e.hdg, e.bz, e.by, e.bx, e.qz, e.qy, e.qx, e.qw};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_fixes.insert(pending_fixes.size(), predict_fix(e));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending_fixes.size() > 0) @(posedge clk);
		repeat (700) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [14:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_q = v;
	endtask

	// checker: one transaction at a time on the result side
	always @(posedge clk) begin
		fix_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind     = m_axis_tuser[0];
			got.accepted = m_axis_tdata[0];
			got.north    = m_axis_tdata[32:1];
			got.east     = m_axis_tdata[64:33];
			got.heading  = m_axis_tdata[80:65];
			if (pending_fixes.size() == 0) begin
				report_mismatch("result with nothing outstanding", 1, 0);
			end else begin
				want = pending_fixes.pop_front();
				if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
				if (got.accepted != want.accepted)
					report_mismatch("quat_accepted", got.accepted, want.accepted);
				if (got.north != want.north) report_mismatch("target_north", got.north, want.north);
				if (got.east != want.east) report_mismatch("target_east", got.east, want.east);
				if (got.heading != want.heading)
					report_mismatch("target_heading", got.heading, want.heading);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off > 0) begin
			m_axis_tready <= 1'b0;
			hold_off <= hold_off - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (!s_axis_tvalid && pending_fixes.size() == 0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic event_t make_attitude(int qw, int qx, int qy, int qz);
		event_t e;
		e = '0;
		e.op = OP_ATTITUDE;
		e.qw = 16'(qw); e.qx = 16'(qx); e.qy = 16'(qy); e.qz = 16'(qz);
		return e;
	endfunction

	function automatic event_t rand_event(logic op);
		event_t e;
		e = 240'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom});
		e.op = op;
		// now and then keep a heading beyond the usual range
		if ($urandom_range(7) != 0)
			e.hdg = 15'($signed($urandom_range(23040)) - 11520);
		if ($urandom_range(3) != 0) begin
			e.bx = $signed(32'($urandom)) >>> $urandom_range(16);
			e.by = $signed(32'($urandom)) >>> $urandom_range(16);
			e.bz = $signed(32'($urandom)) >>> $urandom_range(16);
		end
		return e;
	endfunction

	// near-unit quaternion with random direction, scaled slightly short of unit norm
	function automatic event_t rand_unit_attitude();
		real a, b, c, d, m;
		a = $itor($signed($urandom_range(2000)) - 1000);
		b = $itor($signed($urandom_range(2000)) - 1000);
		c = $itor($signed($urandom_range(2000)) - 1000);
		d = $itor($signed($urandom_range(2000)) - 1000);
		m = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
		return make_attitude($rtoi(16384.0 * a / m), $rtoi(16384.0 * b / m),
			$rtoi(16384.0 * c / m), $rtoi(16384.0 * d / m));
	endfunction

	task automatic test_directed();
		event_t e;
		e = rand_event(OP_XFORM);
		send_event(e);               // reset quaternion, yaw is pi
		e.hdg = 15'sd11520; send_event(e);
		e.hdg = -15'sd11520; send_event(e);
		send_event(make_attitude(16384, 0, 0, 0));
		e = '0; e.op = OP_XFORM; send_event(e);
		e.bx = 32'h7fffffff; e.by = 32'h7fffffff; e.pn = 32'h7fffffff; e.pe = 32'h7fffffff;
		send_event(e);
		e.bx = 32'h80000000; e.by = 32'h80000000; e.pn = 32'h80000000; e.pe = 32'h80000000;
		send_event(e);
		send_event(make_attitude(0, 16384, 0, 0));   // x operand positive, y zero
		e.hdg = 15'sd11520; send_event(e);
		send_event(make_attitude(11585, 0, 0, 11585));
		send_event(rand_event(OP_XFORM));
		send_event(make_attitude(11585, 0, 0, -11585));
		send_event(rand_event(OP_XFORM));
		send_event(make_attitude(8192, 8192, 8192, -8192));   // both atan2 operands zero
		send_event(rand_event(OP_XFORM));
		send_event(make_attitude(-32768, -32768, -32768, -32768));   // rejected
		send_event(make_attitude(32767, 32767, 32767, 32767));
		send_event(rand_event(OP_XFORM));
		send_event(make_attitude(0, 0, 0, 0));
		send_event(make_attitude(0, 0, 0, 16384));
		send_event(rand_event(OP_XFORM));
	endtask

	task automatic test_tolerance();
		drain();
		write_tolerance(15'd0);
		send_event(make_attitude(16384, 0, 0, 0));
		send_event(make_attitude(16385, 0, 0, 0));
		send_event(rand_event(OP_XFORM));
		drain();
		write_tolerance(15'd16384);
		send_event(make_attitude(0, 0, 0, 0));
		send_event(make_attitude(23170, 0, 0, 0));
		send_event(make_attitude(23171, 0, 0, 0));
		send_event(rand_event(OP_XFORM));
		drain();
		write_tolerance(15'h7fff);
		send_event(make_attitude(-32768, -32768, 0, 0));
		send_event(rand_event(OP_XFORM));
		drain();
		write_tolerance(15'd3277);
	endtask

	task automatic test_random(int count);
		event_t e;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: e = rand_event(OP_ATTITUDE);
				1, 2, 3: e = rand_unit_attitude();
				default: e = rand_event(OP_XFORM);
			endcase
			send_event(e);
		end
	endtask

	task automatic test_backpressure();
		hold_off <= 3000;
		test_random(6);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tolerance();
		test_random(110);
		send_idle_pct = 63;
		test_random(100);
		send_idle_pct = 0; recv_stall_pct = 63;
		test_random(100);
		send_idle_pct = 23; recv_stall_pct = 23;
		test_random(100);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_backpressure();
		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ===== files.f =====
hw/rtl/qbnt_pkg.sv
hw/rtl/qbnt_serial_mac.sv
hw/rtl/qbnt_cordic.sv
hw/rtl/quaternion_body_to_ned_transform_core.sv
test/quaternion_body_to_ned_transform_core_test.sv
